// ===== sv/psu_pkg.sv =====
// psu_pkg: payload structs, register indexes and a shared saturation helper
// for the particle state update block. No dependencies.
`timescale 1ns / 1ps

package psu_pkg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
        logic signed [31:0] acc_z;
        logic        [31:0] age_in;
        logic signed [31:0] rotation_in;
        logic               last_particle;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_pos_z;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic        [31:0] age_out;
        logic        [31:0] color_out;
        logic        [31:0] extent_out;
        logic signed [31:0] rotation_out;
        logic               last_out;
    } out_word_t;

    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_INV   = 3'd1;
    localparam logic [2:0] REG_COL_S = 3'd2;
    localparam logic [2:0] REG_COL_M = 3'd3;
    localparam logic [2:0] REG_COL_E = 3'd4;
    localparam logic [2:0] REG_SIZES = 3'd5;
    localparam logic [2:0] REG_RATE  = 3'd6;
    localparam logic [2:0] REG_DT    = 3'd7;

    localparam logic [16:0] LT_ONE = 17'h10000;

    // saturate a 50-bit signed sum to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sd2147483647)       r = 32'sh7fffffff;
        else if (v < -50'sd2147483648) r = 32'sh80000000;
        else                           r = v[31:0];
        return r;
    endfunction

endpackage

// ===== sv/psu_axis.sv =====
// psu_axis: one axis of the Euler step, velocity then position, four stages.
// Depends on psu_pkg for saturation.
`timescale 1ns / 1ps

module psu_axis (
    input  logic               aclk,
    input  logic               en,
    input  logic        [31:0] dt,
    input  logic signed [31:0] pos,
    input  logic signed [31:0] vel,
    input  logic signed [31:0] acc,
    output logic signed [31:0] new_pos,
    output logic signed [31:0] new_vel
);

    logic signed [64:0] pa_reg;
    logic signed [31:0] pos1_reg, vel1_reg, pos2_reg, pos3_reg;
    logic signed [31:0] nv2_reg, nv3_reg, nv4_reg, np_reg;
    logic signed [64:0] pv_reg;
    logic signed [31:0] nv_next, np_next;

    // arithmetic shift is floor division by 65536
    assign nv_next = psu_pkg::sat32(50'(vel1_reg) + 50'(pa_reg >>> 16));
    assign np_next = psu_pkg::sat32(50'(pos3_reg) + 50'(pv_reg >>> 16));

    always_ff @(posedge aclk) begin
        if (en) begin
            pa_reg   <= 65'(acc) * $signed({33'd0, dt});
            pos1_reg <= pos;
            vel1_reg <= vel;
            nv2_reg  <= nv_next;
            pos2_reg <= pos1_reg;
            pv_reg   <= 65'(nv2_reg) * $signed({33'd0, dt});
            nv3_reg  <= nv2_reg;
            pos3_reg <= pos2_reg;
            np_reg   <= np_next;
            nv4_reg  <= nv3_reg;
        end
    end

    assign new_pos = np_reg;
    assign new_vel = nv4_reg;

endmodule

// ===== sv/particle_state_update.sv =====
// particle_state_update: top level, config registers, lifetime, colour,
// extent and rotation paths. Depends on psu_pkg and psu_axis.
`timescale 1ns / 1ps

// Particle state update.
// Input words arrive on s_valid/s_ready/s_data (psu_pkg::in_word_t), results
// leave on m_valid/m_ready/m_data (psu_pkg::out_word_t), one result per word.
// Configuration goes through cfg_we/cfg_addr/cfg_wdata; the user must write
// it only while the block is idle, which the block does not enforce. Registers
// take effect on the next accepted word. Throughput is one word per cycle
// while m_ready keeps up; all four stages advance together (age sum, dt and
// lifetime products, then lifetime clamp, velocity and rotation sums, then
// colour weights and position products, then blends and position sums). The
// whole pipeline advances together; when the receiver holds m_ready low with a
// result waiting, s_ready drops and every stage holds its word, so nothing is
// lost or repeated. Intake is open whenever the output stage is empty or being read.
// Synchronous active-low reset clears all valid bits and loads the register
// reset values: no modes, inverse age 1.0, white colours, zero sizes, zero
// rate and zero step.
module particle_state_update (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  psu_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output psu_pkg::out_word_t  m_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_addr,
    input  logic [63:0]         cfg_wdata
);

    logic [2:0]  mode_reg;
    logic [31:0] inv_reg, cs_reg, cm_reg, ce_reg, rate_reg, dt_reg;
    logic [63:0] sizes_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= '0;
            inv_reg   <= 32'h10000;
            cs_reg    <= '1;
            cm_reg    <= '1;
            ce_reg    <= '1;
            sizes_reg <= '0;
            rate_reg  <= '0;
            dt_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                psu_pkg::REG_MODE:  mode_reg  <= cfg_wdata[2:0];
                psu_pkg::REG_INV:   inv_reg   <= cfg_wdata[31:0];
                psu_pkg::REG_COL_S: cs_reg    <= cfg_wdata[31:0];
                psu_pkg::REG_COL_M: cm_reg    <= cfg_wdata[31:0];
                psu_pkg::REG_COL_E: ce_reg    <= cfg_wdata[31:0];
                psu_pkg::REG_SIZES: sizes_reg <= cfg_wdata;
                psu_pkg::REG_RATE:  rate_reg  <= cfg_wdata[31:0];
                psu_pkg::REG_DT:    dt_reg    <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    logic [3:0] vld_reg;
    logic       en;
    assign en      = !vld_reg[3] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[3];

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en)  vld_reg <= {vld_reg[2:0], s_valid};
    end

    logic signed [31:0] np_x, np_y, np_z, nv_x, nv_y, nv_z;

    psu_axis u_ax (.aclk, .en, .dt(dt_reg), .pos(s_data.pos_x), .vel(s_data.vel_x),
        .acc(s_data.acc_x), .new_pos(np_x), .new_vel(nv_x));
    psu_axis u_ay (.aclk, .en, .dt(dt_reg), .pos(s_data.pos_y), .vel(s_data.vel_y),
        .acc(s_data.acc_y), .new_pos(np_y), .new_vel(nv_y));
    psu_axis u_az (.aclk, .en, .dt(dt_reg), .pos(s_data.pos_z), .vel(s_data.vel_z),
        .acc(s_data.acc_z), .new_pos(np_z), .new_vel(nv_z));

    // stage 1: age sum, lifetime product, rotation product
    logic [31:0]        age1_reg;
    logic [63:0]        ltp1_reg;
    logic signed [64:0] rp1_reg;
    logic signed [31:0] rot1_reg;
    logic               last1_reg;
    logic [32:0]        age_sum;
    assign age_sum = {1'b0, s_data.age_in} + {1'b0, dt_reg};

    // stage 2: clamped lifetime, rotation sum
    logic [16:0]        lt2_reg;
    logic [31:0]        age2_reg;
    logic signed [31:0] rot2_reg;
    logic               last2_reg;
    logic [16:0]        lt_next;
    assign lt_next = (ltp1_reg[63:16] > 48'(psu_pkg::LT_ONE)) ? psu_pkg::LT_ONE
                                                             : ltp1_reg[32:16];

    // stage 3: bezier weights and extent product
    logic [33:0]        wa3_reg, wb3_reg, wc3_reg;
    logic signed [50:0] ep3_reg;
    logic [31:0]        age3_reg, s0_3_reg;
    logic signed [31:0] rot3_reg;
    logic               last3_reg;
    logic [16:0]        u2;
    assign u2 = psu_pkg::LT_ONE - lt2_reg;

    // stage 4: channel blends
    logic [31:0]        age4_reg, col4_reg, ext4_reg;
    logic signed [31:0] rot4_reg;
    logic               last4_reg;
    logic [31:0] col_next, ext_next;
    always_comb begin
        logic [43:0] ch;
        col_next = '0;
        for (int k = 0; k < 4; k++) begin
            ch = 44'(wa3_reg) * 44'(cs_reg[k*8 +: 8]) + 44'(wb3_reg) * 44'(cm_reg[k*8 +: 8])
               + 44'(wc3_reg) * 44'(ce_reg[k*8 +: 8]) + 44'h80000000;
            col_next[k*8 +: 8] = (ch[43:32] > 12'd255) ? 8'hff : ch[39:32];
        end
        ext_next = s0_3_reg + 32'(ep3_reg >>> 16);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            age1_reg  <= age_sum[32] ? 32'hffffffff : age_sum[31:0];
            ltp1_reg  <= 64'(s_data.age_in) * 64'(inv_reg);
            rp1_reg   <= 65'($signed(rate_reg)) * $signed({33'd0, dt_reg});
            rot1_reg  <= s_data.rotation_in;
            last1_reg <= s_data.last_particle;

            lt2_reg   <= lt_next;
            age2_reg  <= age1_reg;
            rot2_reg  <= mode_reg[2] ? psu_pkg::sat32(50'(rot1_reg) + 50'(rp1_reg >>> 16))
                                     : rot1_reg;
            last2_reg <= last1_reg;

            wa3_reg   <= 34'(u2) * 34'(u2);
            wb3_reg   <= 34'({u2, 1'b0}) * 34'(lt2_reg);
            wc3_reg   <= 34'(lt2_reg) * 34'(lt2_reg);
            ep3_reg   <= $signed(33'(sizes_reg[63:32]) - 33'(sizes_reg[31:0]))
                         * $signed({1'b0, lt2_reg});
            s0_3_reg  <= sizes_reg[31:0];
            age3_reg  <= age2_reg;
            rot3_reg  <= rot2_reg;
            last3_reg <= last2_reg;

            age4_reg  <= age3_reg;
            col4_reg  <= mode_reg[0] ? col_next : 32'd0;
            ext4_reg  <= mode_reg[1] ? ext_next : 32'd0;
            rot4_reg  <= rot3_reg;
            last4_reg <= last3_reg;
        end
    end

    assign m_data = {np_x, np_y, np_z, nv_x, nv_y, nv_z,
                     age4_reg, col4_reg, ext4_reg, rot4_reg, last4_reg};

    // a waiting result blocks intake
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("intake open while result stalled");
    // an accepted word reaches the output while the pipeline keeps advancing
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready [*3] ##1 1'b1 |-> m_valid)
        else $error("word lost in pipeline");
    // stall freezes the last stage
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed during stall");

endmodule

// ===== test/tb.sv =====
// tb: self-checking bench for particle_state_update, streams particle words
// against an in-bench Q16.16 integrator under random idling. Needs psu_pkg.
`timescale 1ns / 1ps

module tb;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    psu_pkg::in_word_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    psu_pkg::out_word_t m_data;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_addr = psu_pkg::REG_MODE;
    logic [63:0] cfg_wdata = '0;

    particle_state_update dut (.*);

    always #5 aclk = ~aclk;

    // bench copy of the registers
    logic [2:0] mode_q;
    logic [31:0] inv_age_q, col_s_q, col_m_q, col_e_q, rate_q, dt_q;
    logic [63:0] sizes_q;

    psu_pkg::in_word_t pending_words[$];
    psu_pkg::out_word_t updated_records[$];
    int mismatches = 0;
    int unexpected = 0;
    bit calm = 1'b0;

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // v + floor(x*dt/2^16), saturated; >>> floors on signed values
    function automatic logic signed [31:0] step_add(longint v, longint x, logic [31:0] dt);
        longint p;
        p = x * longint'({32'b0, dt});
        return clamp32(v + (p >>> 16));
    endfunction

    function automatic psu_pkg::out_word_t integrate(psu_pkg::in_word_t w);
        psu_pkg::out_word_t r;
        longint lt, u, wa, wb, wc, ch, s0, s1;
        logic [63:0] agesum;
        r.new_vel_x = step_add(w.vel_x, w.acc_x, dt_q);
        r.new_vel_y = step_add(w.vel_y, w.acc_y, dt_q);
        r.new_vel_z = step_add(w.vel_z, w.acc_z, dt_q);
        r.new_pos_x = step_add(w.pos_x, r.new_vel_x, dt_q);
        r.new_pos_y = step_add(w.pos_y, r.new_vel_y, dt_q);
        r.new_pos_z = step_add(w.pos_z, r.new_vel_z, dt_q);
        agesum = {32'b0, w.age_in} + {32'b0, dt_q};
        r.age_out = agesum[32] ? 32'hffffffff : agesum[31:0];
        lt = longint'(({32'b0, w.age_in} * {32'b0, inv_age_q}) >> 16);
        if (lt > 65536) lt = 65536;
        r.color_out = '0;
        if (mode_q[0]) begin
            u = 65536 - lt;
            wa = u * u;
            wb = 2 * u * lt;
            wc = lt * lt;
            for (int sh = 24; sh >= 0; sh -= 8) begin
                ch = (wa * longint'((col_s_q >> sh) & 8'hff) + wb * longint'((col_m_q >> sh) & 8'hff)
                      + wc * longint'((col_e_q >> sh) & 8'hff) + 64'h80000000) >>> 32;
                if (ch > 255) ch = 255;
                r.color_out[sh +: 8] = ch[7:0];
            end
        end
        s0 = longint'({32'b0, sizes_q[31:0]});
        s1 = longint'({32'b0, sizes_q[63:32]});
        r.extent_out = mode_q[1] ? 32'(s0 + (((s1 - s0) * lt) >>> 16)) : '0;
        r.rotation_out = mode_q[2] ? step_add(w.rotation_in, $signed(rate_q), dt_q)
                                   : w.rotation_in;
        r.last_out = w.last_particle;
        return r;
    endfunction

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 22);
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_words.size() > 0 && !idle_now()) begin
                s_data <= pending_words.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        if (s_valid && s_ready && aresetn)
            updated_records.push_back(integrate(s_data));
    end

    // monitor
    always @(posedge aclk) begin
        m_ready <= aresetn && !idle_now();
        if (aresetn && m_valid && m_ready) begin
            if (updated_records.size() == 0) begin
                unexpected++;
                if (unexpected + mismatches <= 10)
                    $display("unexpected word %h", m_data);
            end else begin
                psu_pkg::out_word_t e;
                e = updated_records.pop_front();
                if (e !== m_data) begin
                    mismatches++;
                    if (mismatches + unexpected <= 10)
                        $display("mismatch: expected %h actual %h", e, m_data);
                end
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            psu_pkg::REG_MODE:  mode_q = v[2:0];
            psu_pkg::REG_INV:   inv_age_q = v[31:0];
            psu_pkg::REG_COL_S: col_s_q = v[31:0];
            psu_pkg::REG_COL_M: col_m_q = v[31:0];
            psu_pkg::REG_COL_E: col_e_q = v[31:0];
            psu_pkg::REG_SIZES: sizes_q = v;
            psu_pkg::REG_RATE:  rate_q = v[31:0];
            default:            dt_q = v[31:0];
        endcase
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || s_valid || updated_records.size() > 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic logic [31:0] rnd_field();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(65535) << $urandom_range(16);
            3: return -($urandom_range(65535) << $urandom_range(16));
            default: return $urandom;
        endcase
    endfunction

    function automatic psu_pkg::in_word_t rnd_word();
        psu_pkg::in_word_t w;
        w.pos_x = rnd_field(); w.pos_y = rnd_field(); w.pos_z = rnd_field();
        w.vel_x = rnd_field(); w.vel_y = rnd_field(); w.vel_z = rnd_field();
        w.acc_x = rnd_field(); w.acc_y = rnd_field(); w.acc_z = rnd_field();
        w.age_in = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h30000);
        w.rotation_in = rnd_field();
        w.last_particle = $urandom_range(1);
        return w;
    endfunction

    task automatic config_set(int k);
        write_reg(psu_pkg::REG_MODE, (k == 0) ? 64'd7 : 64'($urandom));
        write_reg(psu_pkg::REG_INV, (k == 1) ? 64'hffffffff : (k == 2) ? 64'd0
                                    : 64'($urandom_range(32'h30000)));
        write_reg(psu_pkg::REG_COL_S, (k == 1) ? 64'd0 : 64'($urandom));
        write_reg(psu_pkg::REG_COL_M, (k == 1) ? 64'hffffffff : 64'($urandom));
        write_reg(psu_pkg::REG_COL_E, (k == 2) ? 64'd0 : 64'($urandom));
        write_reg(psu_pkg::REG_SIZES, (k == 1) ? 64'hffffffff_00000000
                                      : (k == 2) ? 64'h00000000_ffffffff
                                      : {$urandom, $urandom});
        write_reg(psu_pkg::REG_RATE, (k == 1) ? 64'h7fffffff : (k == 2) ? 64'h80000000
                                     : 64'($urandom));
        write_reg(psu_pkg::REG_DT, (k == 1) ? 64'hffffffff : (k == 2) ? 64'd1
                                   : 64'($urandom_range(32'h20000)));
    endtask

    initial begin
        psu_pkg::in_word_t w;
        mode_q = '0; inv_age_q = 32'h10000; col_s_q = '1; col_m_q = '1; col_e_q = '1;
        sizes_q = '0; rate_q = '0; dt_q = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        // reset values with modes off, then all modes on with a real step
        pending_words.push_back('0);
        drain();
        write_reg(psu_pkg::REG_DT, 64'h10000);
        write_reg(psu_pkg::REG_MODE, 64'd7);
        write_reg(psu_pkg::REG_SIZES, 64'h00050000_00010000);
        write_reg(psu_pkg::REG_RATE, 64'hfffe0000);
        w = '0; pending_words.push_back(w);
        w = '1; pending_words.push_back(w);
        w = '0; w.pos_x = 32'h7fffffff; w.vel_x = 32'h7fffffff; w.acc_x = 32'h7fffffff;
        w.pos_y = 32'h80000000; w.vel_y = 32'h80000000; w.acc_y = 32'h80000000;
        w.age_in = 32'hffffffff; w.rotation_in = 32'h80000000; w.last_particle = 1;
        pending_words.push_back(w);
        w.age_in = 32'h8000; w.rotation_in = 32'h7fffffff; pending_words.push_back(w);
        w.age_in = 32'h10000; w.pos_z = 32'hffffffff; w.acc_z = 32'hffff0001;
        pending_words.push_back(w);
        for (int i = 0; i < 10; i++) pending_words.push_back(rnd_word());
        drain();
        for (int k = 0; k < 6; k++) begin
            config_set(k);
            calm = (k == 3);
            for (int i = 0; i < 75; i++) pending_words.push_back(rnd_word());
            drain();
        end
        calm = 1'b0;
        if (mismatches == 0 && unexpected == 0)
            $display("particle_state_update regression: pass");
        else
            $display("particle_state_update regression: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("particle_state_update regression: fail");
        $finish;
    end
endmodule

// ===== files.f =====
sv/psu_pkg.sv
sv/psu_axis.sv
sv/particle_state_update.sv
test/tb.sv
